FILE: design/sab_pkg.sv
// Package of shared constants and types for the shift-add / Booth multiplier.
package sab_pkg;

    localparam int SAB_WIDTH  = 16;
    localparam int SAB_OP_W   = 16;
    localparam int SAB_PROD_W = 32;
    localparam int SAB_CNT_W  = 5;

    typedef enum logic {
        ALG_ADD_SHIFT = 1'b0,
        ALG_BOOTH     = 1'b1
    } t_alg_mode;

endpackage

FILE: design/sab_if.sv
// Valid/ready channel interfaces for the multiplier operands and results.
interface sab_in_if import sab_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAB_OP_W-1:0] multiplicand_bits;
    logic [SAB_OP_W-1:0] multiplier_bits;

    modport source (output valid, output multiplicand_bits, output multiplier_bits,
                    input ready);
    modport sink   (input valid, input multiplicand_bits, input multiplier_bits,
                    output ready);
endinterface

interface sab_out_if import sab_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SAB_PROD_W-1:0] product_bits;
    logic [SAB_CNT_W-1:0]  add_count;

    modport source (output valid, output product_bits, output add_count, input ready);
    modport sink   (input valid, input product_bits, input add_count, output ready);
endinterface

FILE: design/sab_cell.sv
// One multiplier step cell: a single add-and-shift or Booth iteration, registered.
module sab_cell import sab_pkg::*; #(
    parameter int WIDTH = SAB_WIDTH,
    parameter int CW    = $clog2(SAB_WIDTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alg_mode        i_mode,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_q,
    input  logic [WIDTH-1:0] i_m,
    input  logic             i_qm1,
    input  logic [CW-1:0]    i_cnt,
    input  logic             i_down_ready,
    output logic             o_up_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_a,
    output logic [WIDTH-1:0] o_q,
    output logic [WIDTH-1:0] o_m,
    output logic             o_qm1,
    output logic [CW-1:0]    o_cnt
);

    logic             r_valid;
    logic [WIDTH-1:0] r_a, r_q, r_m;
    logic             r_qm1;
    logic [CW-1:0]    r_cnt;

    logic [WIDTH-1:0] n_a, n_q;
    logic             n_qm1;
    logic [CW-1:0]    n_cnt;

    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] a_mid;
    logic             carry;
    logic             step;
    logic             load;

    // The cell takes a new transaction when it is empty or its content moves on.
    assign load       = !r_valid || i_down_ready;
    assign o_up_ready = load;

    always_comb begin
        sum   = '0;
        a_mid = i_a;
        carry = 1'b0;
        step  = 1'b0;
        n_a   = i_a;
        case (i_mode)
            ALG_ADD_SHIFT: begin
                if (i_q[0]) begin
                    sum   = {1'b0, i_a} + {1'b0, i_m};
                    a_mid = sum[WIDTH-1:0];
                    carry = sum[WIDTH];
                    step  = 1'b1;
                end
                // The carry of this add enters the top of A as A shifts right.
                n_a = {carry, a_mid[WIDTH-1:1]};
            end
            ALG_BOOTH: begin
                if (!i_q[0] && i_qm1) begin
                    a_mid = i_a + i_m;
                    step  = 1'b1;
                end else if (i_q[0] && !i_qm1) begin
                    a_mid = i_a - i_m;
                    step  = 1'b1;
                end
                n_a = {a_mid[WIDTH-1], a_mid[WIDTH-1:1]};
            end
            default: begin
                n_a = i_a;
            end
        endcase
        n_q   = {a_mid[0], i_q[WIDTH-1:1]};
        n_qm1 = i_q[0];
        n_cnt = i_cnt + CW'(step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_a   <= n_a;
            r_q   <= n_q;
            r_m   <= i_m;
            r_qm1 <= n_qm1;
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_q     = r_q;
    assign o_m     = r_m;
    assign o_qm1   = r_qm1;
    assign o_cnt   = r_cnt;

endmodule

FILE: design/shift_add_and_booth_multiplier.sv
// Pipelined multiplier, unsigned add-and-shift or signed radix-2 Booth.
//
// Operands arrive on i_op; a transaction is taken when valid and ready are both
// high. Results leave on o_res under the same handshake: product_bits holds the
// double-width product and add_count the number of add or subtract steps.
// i_cfg_we writes i_cfg_wdata into the mode register: 0 selects unsigned
// add-and-shift, 1 selects signed Booth. Change the mode only while idle.
//
// The datapath is a row of WIDTH step cells, one iteration per cell, each cell
// passing its partial product to the next when that cell has room. A result
// passes through every cell register from acceptance to o_res.valid, and one
// transaction is accepted per cycle while the receiver does not stall.
//
// Reset empties every cell and sets the mode to add-and-shift. When the receiver
// stalls, the result holds in the last cell; each earlier cell keeps moving while
// the one after it has room, so empty slots fill before i_op.ready drops.
module shift_add_and_booth_multiplier import sab_pkg::*; #(
    parameter int WIDTH = SAB_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    sab_in_if.sink        i_op,
    sab_out_if.source     o_res
);

    localparam int CW = $clog2(WIDTH + 1);

    t_alg_mode r_mode;
    t_alg_mode n_mode;

    logic             valid_s [WIDTH+1];
    logic             ready_s [WIDTH+1];
    logic [WIDTH-1:0] a_s     [WIDTH+1];
    logic [WIDTH-1:0] q_s     [WIDTH+1];
    logic [WIDTH-1:0] m_s     [WIDTH+1];
    logic             qm1_s   [WIDTH+1];
    logic [CW-1:0]    cnt_s   [WIDTH+1];

    logic [WIDTH+SAB_OP_W-1:0]     cand_ext;
    logic [WIDTH+SAB_OP_W-1:0]     plier_ext;
    logic [2*WIDTH+SAB_PROD_W-1:0] prod_ext;
    logic [CW+SAB_CNT_W-1:0]       cnt_ext;

    assign n_mode = i_cfg_we ? t_alg_mode'(i_cfg_wdata) : r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ALG_ADD_SHIFT;
        end else begin
            r_mode <= n_mode;
        end
    end

    // Operands are cut or zero-extended to WIDTH bits.
    assign cand_ext  = {{WIDTH{1'b0}}, i_op.multiplicand_bits};
    assign plier_ext = {{WIDTH{1'b0}}, i_op.multiplier_bits};

    assign valid_s[0] = i_op.valid;
    assign a_s[0]     = '0;
    assign q_s[0]     = cand_ext[WIDTH-1:0];
    assign m_s[0]     = plier_ext[WIDTH-1:0];
    assign qm1_s[0]   = 1'b0;
    assign cnt_s[0]   = '0;
    assign i_op.ready = ready_s[0];

    genvar g;
    generate
        for (g = 0; g < WIDTH; g++) begin : g_cell
            sab_cell #(
                .WIDTH (WIDTH),
                .CW    (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_mode       (r_mode),
                .i_valid      (valid_s[g]),
                .i_a          (a_s[g]),
                .i_q          (q_s[g]),
                .i_m          (m_s[g]),
                .i_qm1        (qm1_s[g]),
                .i_cnt        (cnt_s[g]),
                .i_down_ready (ready_s[g+1]),
                .o_up_ready   (ready_s[g]),
                .o_valid      (valid_s[g+1]),
                .o_a          (a_s[g+1]),
                .o_q          (q_s[g+1]),
                .o_m          (m_s[g+1]),
                .o_qm1        (qm1_s[g+1]),
                .o_cnt        (cnt_s[g+1])
            );
        end
    endgenerate

    assign ready_s[WIDTH] = o_res.ready;
    assign prod_ext       = {{SAB_PROD_W{1'b0}}, a_s[WIDTH], q_s[WIDTH]};
    assign cnt_ext        = {{SAB_CNT_W{1'b0}}, cnt_s[WIDTH]};

    assign o_res.valid        = valid_s[WIDTH];
    assign o_res.product_bits = prod_ext[SAB_PROD_W-1:0];
    assign o_res.add_count    = cnt_ext[SAB_CNT_W-1:0];

endmodule

FILE: design/sab_checker.sv
// Port-level checker for the multiplier, bound to the top level.
module sab_checker import sab_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [SAB_PROD_W-1:0] i_product_bits,
    input logic [SAB_CNT_W-1:0]  i_add_count
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_product_bits) && $stable(i_add_count))
        else $error("result payload changed while stalled");

    // Reset empties the cell row, so no result follows a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // With the last cell empty the whole row has room for a new transaction.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked although the output stage is empty");

endmodule

bind shift_add_and_booth_multiplier sab_checker u_sab_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_op.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_product_bits (o_res.product_bits),
    .i_add_count    (o_res.add_count)
);

FILE: tb/sv/mul_result_checker.sv
// Checker that predicts every multiplier result and compares it with the output channel.
`timescale 1ns / 100ps

module mul_result_checker import sab_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    sab_in_if     i_op,
    sab_out_if    i_res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [SAB_PROD_W-1:0] product;
        logic [SAB_CNT_W-1:0]  steps;
    } t_mul_result;

    t_alg_mode   alg_mode;
    t_mul_result expected_products [$];

    // Steps through the chosen scheme one iteration at a time, as the cells do.
    function automatic t_mul_result predict_product(input t_alg_mode mode,
                                                    input logic [SAB_WIDTH-1:0] mcand,
                                                    input logic [SAB_WIDTH-1:0] mplier);
        logic [SAB_WIDTH-1:0] acc;
        logic [SAB_WIDTH-1:0] scan;
        logic [SAB_WIDTH-1:0] negated;
        logic [SAB_WIDTH:0]   sum;
        logic                 carry;
        logic                 prev_bit;
        logic                 sign;
        logic [SAB_CNT_W-1:0] steps;
        t_mul_result          res;
        acc      = '0;
        scan     = mcand;
        negated  = ~mplier + 1'b1;
        prev_bit = 1'b0;
        steps    = '0;
        for (int i = 0; i < SAB_WIDTH; i++) begin
            if (mode == ALG_BOOTH) begin
                if (scan[0] == 1'b0 && prev_bit == 1'b1) begin
                    acc   = acc + mplier;
                    steps = steps + 1'b1;
                end else if (scan[0] == 1'b1 && prev_bit == 1'b0) begin
                    acc   = acc + negated;
                    steps = steps + 1'b1;
                end
                sign     = acc[SAB_WIDTH-1];
                prev_bit = scan[0];
                scan     = {acc[0], scan[SAB_WIDTH-1:1]};
                acc      = {sign, acc[SAB_WIDTH-1:1]};
            end else begin
                carry = 1'b0;
                if (scan[0]) begin
                    sum   = {1'b0, acc} + {1'b0, mplier};
                    carry = sum[SAB_WIDTH];
                    acc   = sum[SAB_WIDTH-1:0];
                    steps = steps + 1'b1;
                end
                scan = {acc[0], scan[SAB_WIDTH-1:1]};
                acc  = {carry, acc[SAB_WIDTH-1:1]};
            end
        end
        res.product = {acc, scan};
        res.steps   = steps;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [SAB_PROD_W-1:0] want,
                                   input logic [SAB_PROD_W-1:0] got);
        o_fail_count++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        alg_mode     = ALG_ADD_SHIFT;
    end

    always @(posedge i_clk) begin
        t_mul_result want;
        if (!i_rst_n) begin
            alg_mode = ALG_ADD_SHIFT;
            expected_products.delete();
        end else begin
            if (i_op.valid && i_op.ready) begin
                expected_products = {expected_products,
                                     predict_product(alg_mode, i_op.multiplicand_bits,
                                                     i_op.multiplier_bits)};
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_products.size() == 0) begin
                    report_mismatch("unexpected transaction", '0, i_res.product_bits);
                end else begin
                    want = expected_products.pop_front();
                    if (i_res.product_bits !== want.product) begin
                        report_mismatch("product_bits", want.product, i_res.product_bits);
                    end
                    if (i_res.add_count !== want.steps) begin
                        report_mismatch("add_count", SAB_PROD_W'(want.steps),
                                        SAB_PROD_W'(i_res.add_count));
                    end
                end
            end
            // The mode register takes the new value at this edge, after this transaction.
            if (i_cfg_we) begin
                alg_mode = t_alg_mode'(i_cfg_wdata);
            end
        end
        o_pending = expected_products.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the multiplier testbench: clock, reset, operand stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module testbench import sab_pkg::*;;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = SAB_WIDTH + 8;
    localparam int N_CORNERS    = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;

    // Receiver stall pattern state.
    int   stall_style = 0;
    int   stall_left  = 0;
    int   stall_tick  = 0;
    int   stall_period = 1;
    int   stall_duty   = 1;

    logic [SAB_OP_W-1:0] corner_mcand [N_CORNERS] = '{
        16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h8000,
        16'h7FFF, 16'h0001, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF
    };
    logic [SAB_OP_W-1:0] corner_mplier [N_CORNERS] = '{
        16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF,
        16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000
    };

    sab_in_if  op_ch ();
    sab_out_if res_ch ();

    shift_add_and_booth_multiplier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (op_ch),
        .o_res       (res_ch)
    );

    mul_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (op_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("shift_add_and_booth_multiplier regression: fail");
            $finish;
        end
    end

    // The receiver switches between full rate, random stalls and periodic stalls.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style  = $urandom_range(0, 3);
            stall_left   = $urandom_range(8, 80);
            stall_period = $urandom_range(2, 8);
            stall_duty   = $urandom_range(1, stall_period);
            stall_tick   = 0;
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_style)
            0: begin
                res_ch.ready = 1'b1;
            end
            1: begin
                res_ch.ready = ($urandom_range(0, 3) != 0);
            end
            2: begin
                res_ch.ready = ($urandom_range(0, 3) == 0);
            end
            default: begin
                res_ch.ready = ((stall_tick % stall_period) < stall_duty);
            end
        endcase
    end

    function automatic logic [SAB_OP_W-1:0] pick_operand();
        logic [SAB_OP_W-1:0] val;
        case ($urandom_range(0, 7))
            0: val = 16'hFFFF;
            1: val = 16'h8000;
            2: val = 16'h7FFF;
            3: val = 16'h0001 << $urandom_range(0, SAB_OP_W - 1);
            4: val = ~(16'h0001 << $urandom_range(0, SAB_OP_W - 1));
            5: val = SAB_OP_W'($urandom_range(0, 15));
            default: val = SAB_OP_W'($urandom);
        endcase
        return val;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, so a burst keeps valid high from one transaction to the next.
    task automatic push_operands(input logic [SAB_OP_W-1:0] mcand,
                                 input logic [SAB_OP_W-1:0] mplier);
        op_ch.valid             = 1'b1;
        op_ch.multiplicand_bits = mcand;
        op_ch.multiplier_bits   = mplier;
        do @(posedge i_clk); while (!op_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        op_ch.valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        op_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_mode(input t_alg_mode mode);
        wait_drained();
        i_cfg_wdata = mode;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic corner_operands();
        for (int k = 0; k < N_CORNERS; k++) begin
            push_operands(corner_mcand[k], corner_mplier[k]);
            if ($urandom_range(0, 2) == 0) begin
                idle_cycles($urandom_range(1, 3));
            end
        end
    endtask

    task automatic random_operands(input int n_items);
        int  burst_left;
        bit  gapless;
        gapless    = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(1, 24);
        for (int k = 0; k < n_items; k++) begin
            push_operands(pick_operand(), pick_operand());
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (!gapless) begin
                    idle_cycles($urandom_range(1, 7));
                end
            end
        end
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_wdata             = 1'b0;
        op_ch.valid             = 1'b0;
        op_ch.multiplicand_bits = '0;
        op_ch.multiplier_bits   = '0;
        res_ch.ready            = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Corner operands in the reset mode, then in Booth mode.
        corner_operands();
        write_mode(ALG_BOOTH);
        corner_operands();
        write_mode(ALG_ADD_SHIFT);

        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                write_mode(($urandom_range(0, 2) == 0) ? t_alg_mode'(p % 2)
                                                       : t_alg_mode'($urandom_range(0, 1)));
            end
            random_operands($urandom_range(130, 180));
        end
        write_mode(ALG_BOOTH);
        random_operands(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("shift_add_and_booth_multiplier regression: pass");
        end else begin
            $display("shift_add_and_booth_multiplier regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sab_pkg.sv
design/sab_if.sv
design/sab_cell.sv
design/shift_add_and_booth_multiplier.sv
design/sab_checker.sv
tb/sv/mul_result_checker.sv
tb/sv/testbench.sv
